// ===== src/v3alu_pkg.sv =====
// Package: the shared opcode type for the vector3 ALU.
package v3alu_pkg;
   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_DOT   = 3'd2,
      OP_CROSS = 3'd3,
      OP_SCALE = 3'd4,
      OP_MAG   = 3'd5,
      OP_NORM  = 3'd6,
      OP_NONE  = 3'd7
   } opcode_type;
endpackage

// ===== src/v3alu_lane.sv =====
// One lane: two signed products at double width, registered.
module v3alu_lane import v3alu_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic                         clock,
   input  logic signed [WORD_BITS-1:0]  p0_a,
   input  logic signed [WORD_BITS-1:0]  p0_b,
   input  logic signed [WORD_BITS-1:0]  p1_a,
   input  logic signed [WORD_BITS-1:0]  p1_b,
   output logic signed [2*WORD_BITS-1:0] prod0_ff,
   output logic signed [2*WORD_BITS-1:0] prod1_ff
);
   logic signed [2*WORD_BITS-1:0] prod0_in, prod1_in;

   // Form both exact products
   always_comb begin
      prod0_in = p0_a * p0_b;
      prod1_in = p1_a * p1_b;
   end

   always_ff @(posedge clock) begin
      prod0_ff <= prod0_in;
      prod1_ff <= prod1_in;
   end
endmodule

// ===== src/v3alu_sqrt.sv =====
// Pipelined square root: one result bit per stage, rounded to nearest.
module v3alu_sqrt #(
   parameter int IN_BITS  = 98,
   parameter int OUT_BITS = 33
) (
   input  logic                 clock,
   input  logic [IN_BITS-1:0]   rad,
   output logic [OUT_BITS:0]    root_ff
);
   localparam int RB = 2*OUT_BITS + 2;
   logic [RB-1:0]     rad_ff  [OUT_BITS+1];
   logic [OUT_BITS:0] m_ff    [OUT_BITS+1];
   logic [RB-1:0]     t_sq;
   logic [OUT_BITS:0] t;
   logic [RB-1:0]     rem;

   always_ff @(posedge clock) begin
      rad_ff[0] <= RB'(rad);
      m_ff[0]   <= '0;
   end

   // Try one bit per stage, most significant first
   for (genvar i = 0; i < OUT_BITS; i++) begin : g_stage
      logic [OUT_BITS:0] tt;
      logic [RB-1:0]     sq;
      always_comb begin
         tt = m_ff[i] | ((OUT_BITS+1)'(1) << (OUT_BITS-1-i));
         sq = RB'(tt) * RB'(tt);
      end
      always_ff @(posedge clock) begin
         rad_ff[i+1] <= rad_ff[i];
         m_ff[i+1]   <= (sq <= rad_ff[i]) ? tt : m_ff[i];
      end
   end

   // Round: add one when remainder exceeds m
   always_comb begin
      t    = m_ff[OUT_BITS];
      t_sq = RB'(t) * RB'(t);
      rem  = rad_ff[OUT_BITS] - t_sq;
   end

   always_ff @(posedge clock) begin
      root_ff <= (rem > RB'(t)) ? t + 1'b1 : t;
   end
endmodule

// ===== src/v3alu_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
module v3alu_div #(
   parameter int N_BITS = 64,
   parameter int D_BITS = 34,
   parameter int Q_BITS = 64
) (
   input  logic              clock,
   input  logic [N_BITS-1:0] num,
   input  logic [D_BITS-1:0] den,
   output logic [Q_BITS-1:0] quot_ff
);
   localparam int RW = D_BITS + 1;
   logic [N_BITS-1:0] n_ff [Q_BITS+1];
   logic [D_BITS-1:0] d_ff [Q_BITS+1];
   logic [RW-1:0]     r_ff [Q_BITS+1];
   logic [Q_BITS-1:0] q_ff [Q_BITS+1];

   always_ff @(posedge clock) begin
      n_ff[0] <= num;
      d_ff[0] <= den;
      r_ff[0] <= '0;
      q_ff[0] <= '0;
   end

   // Shift in one numerator bit and subtract when it fits
   for (genvar i = 0; i < Q_BITS; i++) begin : g_stage
      logic [RW:0] sh;
      always_comb begin
         sh = {r_ff[i], n_ff[i][N_BITS-1-i]};
      end
      always_ff @(posedge clock) begin
         n_ff[i+1] <= n_ff[i];
         d_ff[i+1] <= d_ff[i];
         if (sh >= (RW+1)'(d_ff[i])) begin
            r_ff[i+1] <= RW'(sh - (RW+1)'(d_ff[i]));
            q_ff[i+1] <= {q_ff[i][Q_BITS-2:0], 1'b1};
         end else begin
            r_ff[i+1] <= RW'(sh);
            q_ff[i+1] <= {q_ff[i][Q_BITS-2:0], 1'b0};
         end
      end
   end

   assign quot_ff = q_ff[Q_BITS];
endmodule

// ===== src/vector3_alu_unit.sv =====
// Top level: vector3 ALU with three product lanes, sqrt and divide pipelines.
// Fully pipelined: a new item is taken every cycle (busy stays low) and each
// result strobes out in order. The delay is set by the normalize path: one
// product stage at the accepting edge, a sum stage, the square-root pipeline
// (WORD_BITS+3 stages), a stage for the divide inputs, the divider
// (WORD_BITS+FRAC_BITS+2 stages) and one output stage; every opcode passes
// through this same chain of registers.
// rsp_valid is high one cycle per result and cannot be held off.
module vector3_alu_unit import v3alu_pkg::*; #(
   parameter int WORD_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_opcode,
   input  logic signed [WORD_BITS-1:0] req_a_x,
   input  logic signed [WORD_BITS-1:0] req_a_y,
   input  logic signed [WORD_BITS-1:0] req_a_z,
   input  logic signed [WORD_BITS-1:0] req_b_x,
   input  logic signed [WORD_BITS-1:0] req_b_y,
   input  logic signed [WORD_BITS-1:0] req_b_z,
   output logic                        rsp_valid,
   output logic signed [WORD_BITS-1:0] rsp_r_x,
   output logic signed [WORD_BITS-1:0] rsp_r_y,
   output logic signed [WORD_BITS-1:0] rsp_r_z,
   output logic signed [WORD_BITS-1:0] rsp_scalar_out,
   output logic                        rsp_overflow
);
   localparam int W     = WORD_BITS;
   localparam int PW    = 2*W;
   localparam int SW    = PW + 3;           // sum width
   localparam int RADW  = PW + 2;           // unsigned sum of squares
   localparam int RTW   = W + 1;            // sqrt bits tried
   localparam int NUMW  = W + FRAC_BITS + 1;
   localparam int DENW  = RTW + 1;
   localparam int SQ_LAT  = RTW + 1;
   localparam int DV_LAT  = NUMW + 1;
   localparam int DLY    = SQ_LAT + 1 + DV_LAT; // delay-line tap that lines up with the divider output
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

   typedef struct packed {
      logic                valid;
      opcode_type          op;
      logic signed [W-1:0] ax, ay, az;
      logic                a_zero;
   } ctl_type;

   typedef struct packed {
      logic signed [W-1:0] rx, ry, rz, sc;
      logic                ovf;
   } res_type;

   assign busy = 1'b0;

   // Pick lane operands by opcode
   logic signed [W-1:0] l0a [3], l0b [3], l1a [3], l1b [3];
   always_comb begin
      case (opcode_type'(req_opcode))
         OP_CROSS: begin
            l0a = '{req_a_y, req_a_z, req_a_x}; l0b = '{req_b_z, req_b_x, req_b_y};
            l1a = '{req_a_z, req_a_x, req_a_y}; l1b = '{req_b_y, req_b_z, req_b_x};
         end
         OP_SCALE: begin
            l0a = '{req_a_x, req_a_y, req_a_z}; l0b = '{req_b_x, req_b_x, req_b_x};
            l1a = '{'0, '0, '0}; l1b = '{'0, '0, '0};
         end
         OP_MAG, OP_NORM: begin
            l0a = '{req_a_x, req_a_y, req_a_z}; l0b = l0a;
            l1a = '{'0, '0, '0}; l1b = '{'0, '0, '0};
         end
         default: begin
            l0a = '{req_a_x, req_a_y, req_a_z}; l0b = '{req_b_x, req_b_y, req_b_z};
            l1a = '{'0, '0, '0}; l1b = '{'0, '0, '0};
         end
      endcase
   end

   logic signed [PW-1:0] p0 [3], p1 [3];
   for (genvar g = 0; g < 3; g++) begin : g_lane
      v3alu_lane #(.WORD_BITS(W)) u_lane (
         .clock(clock), .p0_a(l0a[g]), .p0_b(l0b[g]), .p1_a(l1a[g]), .p1_b(l1b[g]),
         .prod0_ff(p0[g]), .prod1_ff(p1[g]));
   end

   // Stage 1 control, with raw add/sub kept alongside
   ctl_type ctl1_ff;
   logic signed [W:0] as_ff [3];
   always_ff @(posedge clock) begin
      if (reset) ctl1_ff.valid <= 1'b0;
      else       ctl1_ff.valid <= start;
      ctl1_ff.op     <= opcode_type'(req_opcode);
      ctl1_ff.ax     <= req_a_x;
      ctl1_ff.ay     <= req_a_y;
      ctl1_ff.az     <= req_a_z;
      ctl1_ff.a_zero <= (req_a_x == '0) && (req_a_y == '0) && (req_a_z == '0);
      if (req_opcode == OP_SUB) begin
         as_ff[0] <= (W+1)'(req_a_x) - (W+1)'(req_b_x);
         as_ff[1] <= (W+1)'(req_a_y) - (W+1)'(req_b_y);
         as_ff[2] <= (W+1)'(req_a_z) - (W+1)'(req_b_z);
      end else begin
         as_ff[0] <= (W+1)'(req_a_x) + (W+1)'(req_b_x);
         as_ff[1] <= (W+1)'(req_a_y) + (W+1)'(req_b_y);
         as_ff[2] <= (W+1)'(req_a_z) + (W+1)'(req_b_z);
      end
   end

   // Merge stage: combine lane products, round and saturate
   function automatic logic signed [W:0] round_sat(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      logic signed [SW-1:0] s;
      r = v + (SW'(1) <<< (FRAC_BITS-1));
      s = r >>> FRAC_BITS;
      if (s > SW'(WMAX))      round_sat = {1'b1, WMAX};
      else if (s < SW'(WMIN)) round_sat = {1'b1, WMIN};
      else                    round_sat = {1'b0, s[W-1:0]};
   endfunction

   function automatic logic signed [W:0] sat_as(input logic signed [W:0] v);
      if (v > (W+1)'(WMAX))      sat_as = {1'b1, WMAX};
      else if (v < (W+1)'(WMIN)) sat_as = {1'b1, WMIN};
      else                       sat_as = {1'b0, v[W-1:0]};
   endfunction

   logic signed [SW-1:0] dsum, csum [3];
   logic [W:0] rs [3], rd;
   res_type res2_in;
   always_comb begin
      dsum = SW'(p0[0]) + SW'(p0[1]) + SW'(p0[2]);
      for (int i = 0; i < 3; i++) begin
         csum[i] = SW'(p0[i]) - SW'(p1[i]);
      end
      rd = round_sat(dsum);
      res2_in = '0;
      case (ctl1_ff.op)
         OP_ADD, OP_SUB: begin
            for (int i = 0; i < 3; i++) rs[i] = sat_as(as_ff[i]);
            res2_in.rx = rs[0][W-1:0]; res2_in.ry = rs[1][W-1:0];
            res2_in.rz = rs[2][W-1:0];
            res2_in.ovf = rs[0][W] | rs[1][W] | rs[2][W];
         end
         OP_DOT: begin
            for (int i = 0; i < 3; i++) rs[i] = '0;
            res2_in.sc  = rd[W-1:0];
            res2_in.ovf = rd[W];
         end
         OP_CROSS, OP_SCALE: begin
            for (int i = 0; i < 3; i++) rs[i] = round_sat(csum[i]);
            res2_in.rx = rs[0][W-1:0]; res2_in.ry = rs[1][W-1:0];
            res2_in.rz = rs[2][W-1:0];
            res2_in.ovf = rs[0][W] | rs[1][W] | rs[2][W];
         end
         default: begin
            for (int i = 0; i < 3; i++) rs[i] = '0;
         end
      endcase
   end

   // Sum of squares for magnitude and normalize
   logic [RADW-1:0] rad_ff;
   ctl_type ctl2_ff;
   res_type res2_ff;
   always_ff @(posedge clock) begin
      if (reset) ctl2_ff.valid <= 1'b0;
      else       ctl2_ff.valid <= ctl1_ff.valid;
      ctl2_ff.op     <= ctl1_ff.op;
      ctl2_ff.ax     <= ctl1_ff.ax;
      ctl2_ff.ay     <= ctl1_ff.ay;
      ctl2_ff.az     <= ctl1_ff.az;
      ctl2_ff.a_zero <= ctl1_ff.a_zero;
      rad_ff  <= RADW'(dsum);
      res2_ff <= res2_in;
   end

   logic [RTW:0] root;
   v3alu_sqrt #(.IN_BITS(RADW), .OUT_BITS(RTW)) u_sqrt (
      .clock(clock), .rad(rad_ff), .root_ff(root));

   // Delay control and early results alongside sqrt and divider
   ctl_type ctl_d [DLY+1];
   res_type res_d [DLY+1];
   logic [RTW:0] m_d [DV_LAT+1];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DLY; i++) ctl_d[i].valid <= 1'b0;
      end else begin
         ctl_d[0].valid <= ctl2_ff.valid;
         for (int i = 1; i <= DLY; i++) ctl_d[i].valid <= ctl_d[i-1].valid;
      end
      ctl_d[0].op <= ctl2_ff.op; ctl_d[0].ax <= ctl2_ff.ax;
      ctl_d[0].ay <= ctl2_ff.ay; ctl_d[0].az <= ctl2_ff.az;
      ctl_d[0].a_zero <= ctl2_ff.a_zero;
      res_d[0] <= res2_ff;
      for (int i = 1; i <= DLY; i++) begin
         ctl_d[i].op <= ctl_d[i-1].op; ctl_d[i].ax <= ctl_d[i-1].ax;
         ctl_d[i].ay <= ctl_d[i-1].ay; ctl_d[i].az <= ctl_d[i-1].az;
         ctl_d[i].a_zero <= ctl_d[i-1].a_zero;
         res_d[i] <= res_d[i-1];
      end
   end

   // Divider inputs: |c| << FRAC_BITS + m/2, denominator m (1 when m is zero)
   localparam int CI = SQ_LAT;
   logic [NUMW-1:0] num_ff [3];
   logic [DENW-1:0] den_ff;
   logic [W-1:0] mag_c [3];
   always_comb begin
      mag_c[0] = ctl_d[CI].ax[W-1] ? W'(-ctl_d[CI].ax) : W'(ctl_d[CI].ax);
      mag_c[1] = ctl_d[CI].ay[W-1] ? W'(-ctl_d[CI].ay) : W'(ctl_d[CI].ay);
      mag_c[2] = ctl_d[CI].az[W-1] ? W'(-ctl_d[CI].az) : W'(ctl_d[CI].az);
   end
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         num_ff[i] <= (NUMW'(mag_c[i]) << FRAC_BITS) + NUMW'(root >> 1);
      end
      den_ff <= (root == '0) ? DENW'(1) : DENW'(root);
      m_d[0] <= root;
      for (int i = 1; i <= DV_LAT; i++) m_d[i] <= m_d[i-1];
   end

   logic [NUMW-1:0] q [3];
   for (genvar g = 0; g < 3; g++) begin : g_div
      v3alu_div #(.N_BITS(NUMW), .D_BITS(DENW), .Q_BITS(NUMW)) u_div (
         .clock(clock), .num(num_ff[g]), .den(den_ff), .quot_ff(q[g]));
   end

   // Final merge: apply sign and saturate normalize, saturate magnitude
   function automatic logic [W:0] sat_norm(input logic [NUMW-1:0] qv, input logic neg);
      logic [NUMW:0] s;
      s = neg ? -{1'b0, qv} : {1'b0, qv};
      if (!neg && qv > NUMW'(WMAX))            sat_norm = {1'b1, WMAX};
      else if (neg && qv > NUMW'({1'b0, WMAX}) + 1'b1) sat_norm = {1'b1, WMIN};
      else                                     sat_norm = {1'b0, s[W-1:0]};
   endfunction

   localparam int F = DLY;
   res_type out_in;
   logic [W:0] nx, ny, nz;
   always_comb begin
      out_in = res_d[F];
      nx = sat_norm(q[0], ctl_d[F].ax[W-1]);
      ny = sat_norm(q[1], ctl_d[F].ay[W-1]);
      nz = sat_norm(q[2], ctl_d[F].az[W-1]);
      case (ctl_d[F].op)
         OP_MAG: begin
            if (m_d[DV_LAT] > (RTW+1)'(WMAX)) begin
               out_in.sc = WMAX; out_in.ovf = 1'b1;
            end else begin
               out_in.sc = W'(m_d[DV_LAT]); out_in.ovf = 1'b0;
            end
         end
         OP_NORM: begin
            if (!ctl_d[F].a_zero) begin
               out_in.rx = nx[W-1:0]; out_in.ry = ny[W-1:0]; out_in.rz = nz[W-1:0];
               out_in.ovf = nx[W] | ny[W] | nz[W];
            end
         end
         default: ;
      endcase
   end

   res_type out_ff;
   logic    vld_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= ctl_d[F].valid;
      out_ff <= out_in;
   end

   assign rsp_valid      = vld_ff;
   assign rsp_r_x        = out_ff.rx;
   assign rsp_r_y        = out_ff.ry;
   assign rsp_r_z        = out_ff.rz;
   assign rsp_scalar_out = out_ff.sc;
   assign rsp_overflow   = out_ff.ovf;
endmodule

// ===== tb/sv/tb_vector3_alu_unit.sv =====
// Testbench: vector3 ALU unit checked against a fixed-point predictor.
`timescale 1ns / 100ps

module tb_vector3_alu_unit;
   import v3alu_pkg::*;

   localparam int RANDOM_ITEMS = 1700;
   localparam int PAUSE_AT     = 900;
   localparam int DRAIN_CYCLES = 120;

   typedef struct {
      logic [2:0]         opcode;
      logic signed [31:0] a_x, a_y, a_z, b_x, b_y, b_z;
   } vec_op_type;

   typedef struct {
      logic signed [31:0] r_x, r_y, r_z, scalar_out;
      logic               overflow;
   } vec_res_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [2:0]         req_opcode = '0;
   logic signed [31:0] req_a_x = '0, req_a_y = '0, req_a_z = '0;
   logic signed [31:0] req_b_x = '0, req_b_y = '0, req_b_z = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_r_x, rsp_r_y, rsp_r_z, rsp_scalar_out;
   logic               rsp_overflow;

   vec_op_type  pending_ops[$];
   vec_res_type expected_results[$];
   bit       took_op     = 1'b0;
   bit       stim_done   = 1'b0;
   int       ops_sent    = 0;
   int       results_ok  = 0;
   int       errors      = 0;
   int       sat_seen    = 0;
   int       burst_left  = 4;
   int       gap_left    = 0;
   int       op_hist[8];

   vector3_alu_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode),
      .req_a_x(req_a_x), .req_a_y(req_a_y), .req_a_z(req_a_z),
      .req_b_x(req_b_x), .req_b_y(req_b_y), .req_b_z(req_b_z),
      .rsp_valid(rsp_valid),
      .rsp_r_x(rsp_r_x), .rsp_r_y(rsp_r_y), .rsp_r_z(rsp_r_z),
      .rsp_scalar_out(rsp_scalar_out), .rsp_overflow(rsp_overflow)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Saturate a wide value to one Q16.16 word, flag when clipped
   function automatic logic signed [31:0] clamp_word(input logic signed [127:0] v,
                                                     inout logic ovf);
      if (v > 128'sd2147483647) begin
         ovf = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -128'sd2147483648) begin
         ovf = 1'b1;
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // Round a double-width product to nearest, ties toward plus infinity
   function automatic logic signed [31:0] round_product(input logic signed [127:0] p,
                                                        inout logic ovf);
      return clamp_word((p + 128'sd32768) >>> 16, ovf);
   endfunction

   // Nearest integer square root of the exact sum of squares
   function automatic logic [127:0] root_nearest(input logic [127:0] s);
      logic [127:0] m, t;
      m = '0;
      for (int b = 32; b >= 0; b--) begin
         t = m | (128'd1 << b);
         if (t * t <= s) m = t;
      end
      if (s - m * m > m) m = m + 1;
      return m;
   endfunction

   // One unit-vector component: (|c| << 16) / m rounded to nearest, sign restored
   function automatic logic signed [31:0] unit_component(input logic signed [127:0] c,
                                                         input logic [127:0] m,
                                                         inout logic ovf);
      logic [127:0] q;
      logic [127:0] mag;
      mag = c < 0 ? -c : c;
      q = ((mag << 16) + (m >> 1)) / m;
      if (q > (128'd1 << 62)) q = 128'd1 << 62;
      return clamp_word(c < 0 ? -$signed(q) : $signed(q), ovf);
   endfunction

   function automatic vec_res_type vector_result(input vec_op_type op);
      vec_res_type r;
      logic signed [127:0] ax, ay, az, bx, by, bz, s;
      logic [127:0] m;
      logic ovf;
      ax = op.a_x; ay = op.a_y; az = op.a_z;
      bx = op.b_x; by = op.b_y; bz = op.b_z;
      r = '{default: '0};
      ovf = 1'b0;
      case (opcode_type'(op.opcode))
         OP_ADD: begin
            r.r_x = clamp_word(ax + bx, ovf);
            r.r_y = clamp_word(ay + by, ovf);
            r.r_z = clamp_word(az + bz, ovf);
         end
         OP_SUB: begin
            r.r_x = clamp_word(ax - bx, ovf);
            r.r_y = clamp_word(ay - by, ovf);
            r.r_z = clamp_word(az - bz, ovf);
         end
         OP_DOT: r.scalar_out = round_product(ax * bx + ay * by + az * bz, ovf);
         OP_CROSS: begin
            r.r_x = round_product(ay * bz - az * by, ovf);
            r.r_y = round_product(az * bx - ax * bz, ovf);
            r.r_z = round_product(ax * by - ay * bx, ovf);
         end
         OP_SCALE: begin
            r.r_x = round_product(ax * bx, ovf);
            r.r_y = round_product(ay * bx, ovf);
            r.r_z = round_product(az * bx, ovf);
         end
         OP_MAG: begin
            s = ax * ax + ay * ay + az * az;
            r.scalar_out = clamp_word($signed(root_nearest(s)), ovf);
         end
         OP_NORM: begin
            // zero vector stays zero without a flag
            if (ax != 0 || ay != 0 || az != 0) begin
               s = ax * ax + ay * ay + az * az;
               m = root_nearest(s);
               r.r_x = unit_component(ax, m, ovf);
               r.r_y = unit_component(ay, m, ovf);
               r.r_z = unit_component(az, m, ovf);
            end
         end
         default: ;
      endcase
      r.overflow = ovf;
      return r;
   endfunction

   // Operand mix: full range, small, mid-size and corner values
   function automatic logic signed [31:0] pick_word();
      logic signed [31:0] corners[8];
      corners = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1, 32'sh00010000,
                  -32'sh00010000, 32'sh00008000};
      case ($urandom_range(0, 4))
         0, 1: return $urandom;
         2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
         3: return $signed($urandom) >>> $urandom_range(4, 14);
         default: return corners[$urandom_range(0, 7)];
      endcase
   endfunction

   function automatic vec_op_type make_op(input opcode_type code,
                                       input logic signed [31:0] ax, ay, az, bx, by, bz);
      vec_op_type op;
      op.opcode = code;
      op.a_x = ax; op.a_y = ay; op.a_z = az;
      op.b_x = bx; op.b_y = by; op.b_z = bz;
      return op;
   endfunction

   // Fill the stimulus queue: directed corners, then random operations
   initial begin
      logic signed [31:0] hi, lo;
      vec_op_type op;
      hi = 32'sh7fffffff;
      lo = 32'sh80000000;
      pending_ops.push_back(make_op(OP_ADD, hi, lo, hi, hi, lo, -1));
      pending_ops.push_back(make_op(OP_ADD, lo, 0, 1, lo, 0, -1));
      pending_ops.push_back(make_op(OP_SUB, lo, hi, 0, hi, lo, lo));
      pending_ops.push_back(make_op(OP_DOT, hi, hi, hi, hi, hi, hi));
      pending_ops.push_back(make_op(OP_DOT, lo, lo, lo, hi, hi, hi));
      pending_ops.push_back(make_op(OP_DOT, 1, 0, 0, 32'sh8000, 0, 0));
      pending_ops.push_back(make_op(OP_CROSS, hi, lo, hi, lo, hi, lo));
      pending_ops.push_back(make_op(OP_CROSS, 32'sh10000, 0, 0, 0, 32'sh10000, 0));
      pending_ops.push_back(make_op(OP_SCALE, 1, -1, 3, 32'sh8000, 0, 0));
      pending_ops.push_back(make_op(OP_SCALE, hi, lo, -1, lo, 0, 0));
      pending_ops.push_back(make_op(OP_MAG, lo, lo, lo, 0, 0, 0));
      pending_ops.push_back(make_op(OP_MAG, 0, 0, 0, hi, hi, hi));
      pending_ops.push_back(make_op(OP_MAG, 32'sh30000, 32'sh40000, 0, 0, 0, 0));
      pending_ops.push_back(make_op(OP_NORM, 0, 0, 0, hi, lo, 1));
      pending_ops.push_back(make_op(OP_NORM, 1, 0, 0, 0, 0, 0));
      pending_ops.push_back(make_op(OP_NORM, -1, 0, 0, 0, 0, 0));
      pending_ops.push_back(make_op(OP_NORM, lo, hi, lo, 0, 0, 0));
      pending_ops.push_back(make_op(OP_NORM, 1, 1, 1, 0, 0, 0));
      pending_ops.push_back(make_op(OP_NONE, hi, lo, -1, hi, lo, -1));
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         op.opcode = $urandom_range(0, 7);
         op.a_x = pick_word(); op.a_y = pick_word(); op.a_z = pick_word();
         op.b_x = pick_word(); op.b_y = pick_word(); op.b_z = pick_word();
         pending_ops.push_back(op);
      end
      repeat (6) @(posedge clock);
      @(negedge clock) reset = 1'b0;
   end

   // Driver: present the queue head in bursts, with gaps and one full drain
   always @(negedge clock) begin
      if (took_op) begin
         void'(pending_ops.pop_front());
         took_op = 1'b0;
      end
      if (reset || pending_ops.size() == 0 || gap_left > 0 ||
          (ops_sent == PAUSE_AT && expected_results.size() != 0)) begin
         start <= 1'b0;
         if (gap_left > 0) gap_left--;
      end else begin
         start      <= 1'b1;
         req_opcode <= pending_ops[0].opcode;
         req_a_x    <= pending_ops[0].a_x;
         req_a_y    <= pending_ops[0].a_y;
         req_a_z    <= pending_ops[0].a_z;
         req_b_x    <= pending_ops[0].b_x;
         req_b_y    <= pending_ops[0].b_y;
         req_b_z    <= pending_ops[0].b_z;
         if (--burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
      end
   end

   // Monitor: record each input transfer, check each result transfer
   always @(posedge clock) begin
      vec_op_type  op;
      vec_res_type want;
      if (!reset && start && !busy) begin
         op.opcode = req_opcode;
         op.a_x = req_a_x; op.a_y = req_a_y; op.a_z = req_a_z;
         op.b_x = req_b_x; op.b_y = req_b_y; op.b_z = req_b_z;
         expected_results.push_back(vector_result(op));
         op_hist[req_opcode]++;
         ops_sent++;
         took_op = 1'b1;
      end
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result r=(%h %h %h) s=%h ovf=%b", $time,
                     rsp_r_x, rsp_r_y, rsp_r_z, rsp_scalar_out, rsp_overflow);
         end else begin
            want = expected_results.pop_front();
            if (rsp_r_x !== want.r_x || rsp_r_y !== want.r_y || rsp_r_z !== want.r_z ||
                rsp_scalar_out !== want.scalar_out || rsp_overflow !== want.overflow) begin
               errors++;
               $display("%0t: mismatch expected r=(%h %h %h) s=%h ovf=%b", $time,
                        want.r_x, want.r_y, want.r_z, want.scalar_out, want.overflow);
               $display("%0t:          actual   r=(%h %h %h) s=%h ovf=%b", $time,
                        rsp_r_x, rsp_r_y, rsp_r_z, rsp_scalar_out, rsp_overflow);
            end else begin
               results_ok++;
               if (want.overflow) sat_seen++;
            end
         end
      end
   end

   // Finish: drain outstanding results, then let the pipeline settle
   initial begin
      wait (!reset && pending_ops.size() == 0 && !took_op);
      wait (expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) errors++;
      $display("covered %0d transfers: add %0d sub %0d dot %0d cross %0d scale %0d",
               ops_sent, op_hist[0], op_hist[1], op_hist[2], op_hist[3], op_hist[4]);
      $display("mag %0d norm %0d none %0d; %0d results matched, %0d saturated",
               op_hist[5], op_hist[6], op_hist[7], results_ok, sat_seen);
      if (errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Hang guard
   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end
endmodule
